[hdl/chp_pkg.sv]
// shared constants, types and character helpers of the compass heading sentence parser
// used by chp_front, chp_back and compass_heading_sentence_parser; no dependencies
package chp_pkg;

  localparam logic [7:0] CHAR_START   = 8'h24;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
  localparam logic [7:0] CHAR_PLUS    = 8'h2b;
  localparam logic [7:0] CHAR_MINUS   = 8'h2d;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;

  localparam int SENT_END_POS = 11;
  localparam int FIELD_FIRST  = 7;
  localparam int FIELD_LEN    = 3;
  localparam int FULL_TURN    = 360;
  localparam int HALF_TURN    = 180;

  localparam int Q_DEPTH = 2;
  localparam int QAW     = $clog2(Q_DEPTH);

  localparam int GAIN_W = 16;
  localparam int HEAD_W = 16;
  localparam int VAL_W  = 11;
  localparam int MAG_W  = 9;

  localparam logic [1:0] PS_SKIP   = 2'd0;
  localparam logic [1:0] PS_DIGITS = 2'd1;
  localparam logic [1:0] PS_DONE   = 2'd2;

  typedef logic [FIELD_LEN-1:0][7:0] field_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0a) || (c == 8'h0b) ||
           (c == 8'h0c) || (c == 8'h0d);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  // blanks, optional sign, then digits up to the first non-digit
  function automatic logic signed [VAL_W-1:0] parse_field(input field_t ch);
    logic [1:0]       st;
    logic             neg;
    logic [VAL_W-2:0] val;
    logic [7:0]       c;
    logic [VAL_W-2:0] dig;
    st  = PS_SKIP;
    neg = 1'b0;
    val = '0;
    for (int k = 0; k < FIELD_LEN; k++) begin
      c   = ch[k];
      dig = (VAL_W-1)'(c[3:0]);
      if (st == PS_SKIP) begin
        if (is_blank(c)) begin
          st = PS_SKIP;
        end else if ((c == CHAR_PLUS) || (c == CHAR_MINUS)) begin
          neg = (c == CHAR_MINUS);
          st  = PS_DIGITS;
        end else if (is_digit(c)) begin
          val = dig;
          st  = PS_DIGITS;
        end else begin
          st = PS_DONE;
        end
      end else if (st == PS_DIGITS) begin
        if (is_digit(c)) begin
          val = (val << 3) + (val << 1) + dig;
        end else begin
          st = PS_DONE;
        end
      end
    end
    return neg ? -$signed({1'b0, val}) : $signed({1'b0, val});
  endfunction

  function automatic logic signed [VAL_W-1:0] fold(input logic signed [VAL_W-1:0] v_in);
    logic signed [VAL_W-1:0] v;
    v = v_in;
    if (v > VAL_W'(FULL_TURN)) begin
      v = v - VAL_W'(FULL_TURN);
    end
    if (v > VAL_W'(HALF_TURN)) begin
      v = v - VAL_W'(FULL_TURN);
    end
    return v;
  endfunction

endpackage

[hdl/chp_front.sv]
// front part: sentence framing, field capture and the job queue toward the back part
// depends on chp_pkg
module chp_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  logic [7:0]      rx_byte_i,
  output logic            job_valid_o,
  output chp_pkg::field_t job_o,
  input  logic            job_take_i
);
  import chp_pkg::*;

  logic           in_sentence_q, in_sentence_d;
  logic [3:0]     pos_q, pos_d;
  field_t         field_q;
  logic [3:0]     pos_inc;
  logic           accept;
  logic           job_push;
  logic           field_we;
  logic [1:0]     field_idx;
  field_t         q_mem_q [Q_DEPTH];
  logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QAW:0]   cnt_q, cnt_d;

  assign full    = (cnt_q == (QAW+1)'(Q_DEPTH));
  assign accept  = push && !full;
  assign pos_inc = pos_q + 4'd1;

  always_comb begin
    in_sentence_d = in_sentence_q;
    pos_d         = pos_q;
    job_push      = 1'b0;
    field_we      = 1'b0;
    field_idx     = 2'(pos_inc - 4'(FIELD_FIRST));
    if (accept) begin
      if (rx_byte_i == CHAR_START) begin
        in_sentence_d = 1'b1;
        pos_d         = '0;
      end else if (in_sentence_q) begin
        if (pos_inc == 4'(SENT_END_POS)) begin
          job_push      = 1'b1;
          in_sentence_d = 1'b0;
          pos_d         = '0;
        end else if (rx_byte_i == CHAR_NEWLINE) begin
          in_sentence_d = 1'b0;
          pos_d         = '0;
        end else begin
          pos_d    = pos_inc;
          field_we = (pos_inc >= 4'(FIELD_FIRST)) && (pos_inc < 4'(FIELD_FIRST + FIELD_LEN));
        end
      end
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (job_push && !job_take_i) begin
      cnt_d = cnt_q + (QAW+1)'(1);
    end else if (!job_push && job_take_i) begin
      cnt_d = cnt_q - (QAW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_sentence_q <= 1'b0;
      pos_q         <= '0;
      wr_ptr_q      <= '0;
      rd_ptr_q      <= '0;
      cnt_q         <= '0;
    end else begin
      in_sentence_q <= in_sentence_d;
      pos_q         <= pos_d;
      cnt_q         <= cnt_d;
      if (job_push) begin
        wr_ptr_q <= wr_ptr_q + QAW'(1);
      end
      if (job_take_i) begin
        rd_ptr_q <= rd_ptr_q + QAW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (field_we) begin
      field_q[field_idx] <= rx_byte_i;
    end
    if (job_push) begin
      q_mem_q[wr_ptr_q] <= field_q;
    end
  end

  assign job_valid_o = (cnt_q != '0);
  assign job_o       = q_mem_q[rd_ptr_q];

endmodule

[hdl/chp_back.sv]
// back part: number parse and fold, damping multiply, saturation and the result queue
// depends on chp_pkg
module chp_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [15:0]              gain_q8_i,
  input  logic                     job_valid_i,
  input  chp_pkg::field_t          job_i,
  output logic                     job_take_o,
  output logic                     empty,
  input  logic                     pop,
  output logic signed [15:0]       heading_out_o
);
  import chp_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_SUM  = 2'd2;

  localparam int DIFF_W = HEAD_W + 2;
  localparam int PROD_W = GAIN_W + DIFF_W;
  localparam int SUM_W  = PROD_W - 7;

  logic [1:0]                state_q, state_d;
  logic signed [GAIN_W-1:0]  gain_q;
  logic signed [HEAD_W-1:0]  last_q;
  logic [MAG_W-1:0]          mag_q;
  logic                      neg_q;
  logic signed [PROD_W-1:0]  prod_q;

  logic signed [VAL_W-1:0]   v_fold;
  logic [HEAD_W:0]           last_abs;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [PROD_W-1:0]  prod_adj;
  logic signed [SUM_W-1:0]   damp;
  logic signed [SUM_W-1:0]   term;
  logic signed [SUM_W-1:0]   sum;
  logic signed [HEAD_W-1:0]  sat;

  logic                      out_full;
  logic                      out_push;
  logic                      out_pop;
  logic signed [HEAD_W-1:0]  out_mem_q [Q_DEPTH];
  logic [QAW-1:0]            wr_ptr_q, rd_ptr_q;
  logic [QAW:0]              cnt_q, cnt_d;

  assign v_fold   = fold(parse_field(job_i));
  assign last_abs = last_q[HEAD_W-1] ? (HEAD_W+1)'(-{last_q[HEAD_W-1], last_q})
                                     : (HEAD_W+1)'({1'b0, last_q});
  assign diff     = $signed(DIFF_W'(mag_q)) - $signed(DIFF_W'(last_abs));

  // truncate toward zero on the q8 shift
  assign prod_adj = prod_q + (prod_q[PROD_W-1] ? PROD_W'(255) : PROD_W'(0));
  assign damp     = SUM_W'(prod_adj >>> 8);
  assign term     = neg_q ? -$signed(SUM_W'(mag_q)) : $signed(SUM_W'(mag_q));
  assign sum      = term + damp;

  always_comb begin
    if (sum > $signed(SUM_W'(32767))) begin
      sat = 16'sh7fff;
    end else if (sum < -$signed(SUM_W'(32768))) begin
      sat = -16'sh8000;
    end else begin
      sat = HEAD_W'(sum);
    end
  end

  assign out_full   = (cnt_q == (QAW+1)'(Q_DEPTH));
  assign out_push   = (state_q == S_SUM) && !out_full;
  assign out_pop    = pop && !empty;
  assign job_take_o = (state_q == S_IDLE) && job_valid_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        state_d = S_SUM;
      end
      S_SUM: begin
        if (!out_full) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (out_push && !out_pop) begin
      cnt_d = cnt_q + (QAW+1)'(1);
    end else if (!out_push && out_pop) begin
      cnt_d = cnt_q - (QAW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      gain_q   <= '0;
      last_q   <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        gain_q <= $signed(gain_q8_i);
      end
      if (out_push) begin
        last_q   <= sat;
        wr_ptr_q <= wr_ptr_q + QAW'(1);
      end
      if (out_pop) begin
        rd_ptr_q <= rd_ptr_q + QAW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_take_o) begin
      neg_q <= v_fold[VAL_W-1];
      mag_q <= v_fold[VAL_W-1] ? MAG_W'(-v_fold) : MAG_W'(v_fold);
    end
    if (state_q == S_MUL) begin
      prod_q <= PROD_W'(gain_q) * PROD_W'(diff);
    end
    if (out_push) begin
      out_mem_q[wr_ptr_q] <= sat;
    end
  end

  assign empty         = (cnt_q == '0);
  assign heading_out_o = out_mem_q[rd_ptr_q];

endmodule

[hdl/compass_heading_sentence_parser.sv]
// top level of the compass heading sentence parser
// instantiates chp_front and chp_back, depends on chp_pkg
//
// usage:
//   input: one received byte per item on rx_byte_i, taken when push is high and full is low.
//   a '$' opens a sentence; the 11th byte after it closes the sentence and yields one
//   heading item, a newline before that drops the sentence, bytes outside a sentence
//   are ignored.
//   output: the oldest heading is on heading_out_o while empty is low and is removed when
//   pop is high at a clock edge.
//   config: gain_q8_i is written when cfg_valid_i is high; cfg_ready_o is always high.
//   write it only while no sentence result is pending.
//   throughput: one byte per cycle while full is low. the heading of a closing byte
//   passes queue, parse and fold, multiply, sum and saturate before it is visible.
//   a two-entry job queue sits between the parts and a two-entry result queue at the
//   output; when pop stays low both fill and full rises, holding off further bytes.
//   reset: no sentence open, gain and last heading zero, both queues empty.
module compass_heading_sentence_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         rx_byte_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] heading_out_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [15:0]        gain_q8_i
);
  import chp_pkg::*;

  logic   job_valid;
  field_t job;
  logic   job_take;

  assign cfg_ready_o = 1'b1;

  chp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .rx_byte_i   (rx_byte_i),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_take_i  (job_take)
  );

  chp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .gain_q8_i     (gain_q8_i),
    .job_valid_i   (job_valid),
    .job_i         (job),
    .job_take_o    (job_take),
    .empty         (empty),
    .pop           (pop),
    .heading_out_o (heading_out_o)
  );

endmodule

[sim/compass_heading_sentence_parser_tb.sv]
// self-checking testbench of compass_heading_sentence_parser: random bytes and sentences in,
// headings checked against an in-bench predictor; depends on chp_pkg and the block's rtl
`timescale 1ns / 100ps

module compass_heading_sentence_parser_tb;
  import chp_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int LIMIT_CYCLES = 500000;
  localparam int PHASE_BYTES  = 150;
  localparam int HOLD_CYCLES  = 600;

  class heading_scoreboard;
    logic signed [15:0] gain;
    logic signed [15:0] last_heading;
    bit                 in_sent;
    int unsigned        pos;
    logic [7:0]         field [FIELD_LEN];
    logic signed [15:0] heading_queue [$];
    int                 errors;

    function new();
      gain         = '0;
      last_heading = '0;
      in_sent      = 1'b0;
      pos          = 0;
      errors       = 0;
      foreach (field[k]) field[k] = '0;
    endfunction

    task report(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void set_gain(input logic signed [15:0] g);
      gain = g;
    endfunction

    // blanks, optional sign, digits; take 360 off above 360 and again above 180, then damp against the last heading
    function logic signed [15:0] damped_heading();
      int     i;
      int     v;
      bit     neg;
      longint m;
      longint l;
      longint d;
      longint sum;
      i   = 0;
      v   = 0;
      neg = 1'b0;
      while (i < FIELD_LEN && (field[i] == 8'h20 || (field[i] >= 8'h09 && field[i] <= 8'h0d)))
        i++;
      if (i < FIELD_LEN && (field[i] == CHAR_PLUS || field[i] == CHAR_MINUS)) begin
        neg = (field[i] == CHAR_MINUS);
        i++;
      end
      while (i < FIELD_LEN && field[i] >= CHAR_ZERO && field[i] <= CHAR_NINE) begin
        v = v * 10 + int'(field[i] - CHAR_ZERO);
        i++;
      end
      if (neg) v = -v;
      if (v > FULL_TURN) v -= FULL_TURN;
      if (v > HALF_TURN) v -= FULL_TURN;
      neg = (v < 0);
      m   = neg ? -v : v;
      l   = last_heading;
      if (l < 0) l = -l;
      d   = (longint'(gain) * (m - l)) / 256;
      sum = (neg ? -m : m) + d;
      if (sum > 32767) sum = 32767;
      if (sum < -32768) sum = -32768;
      return 16'(sum);
    endfunction

    function void note_byte(input logic [7:0] c);
      if (c == CHAR_START) begin
        in_sent = 1'b1;
        pos     = 0;
      end else if (in_sent) begin
        pos++;
        if (pos >= SENT_END_POS) begin
          last_heading = damped_heading();
          heading_queue.push_back(last_heading);
          in_sent = 1'b0;
          pos     = 0;
        end else if (c == CHAR_NEWLINE) begin
          in_sent = 1'b0;
          pos     = 0;
        end else if (pos >= FIELD_FIRST && pos < FIELD_FIRST + FIELD_LEN) begin
          field[pos - FIELD_FIRST] = c;
        end
      end
    endfunction

    task check_heading(input logic signed [15:0] got);
      logic signed [15:0] want;
      if (heading_queue.size() == 0) begin
        report($sformatf("heading %0d with none expected", got));
      end else begin
        want = heading_queue.pop_front();
        if (got !== want) report($sformatf("heading_out %0d, expected %0d", got, want));
      end
    endtask
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               push;
  logic               full;
  logic [7:0]         rx_byte_i;
  logic               empty;
  logic               pop;
  logic signed [15:0] heading_out_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [15:0]        gain_q8_i;

  heading_scoreboard board;
  bit                snd_steady;
  bit                rcv_steady;
  bit                rcv_hold_req;
  int                counted;
  int unsigned       cycles;

  compass_heading_sentence_parser DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .rx_byte_i     (rx_byte_i),
    .empty         (empty),
    .pop           (pop),
    .heading_out_o (heading_out_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .gain_q8_i     (gain_q8_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
        $display("compass_heading_sentence_parser regression: fail");
        $finish;
      end
    end
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] body_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CHAR_START || c == CHAR_NEWLINE);
    return c;
  endfunction

  function automatic logic [7:0] field_char();
    case ($urandom_range(0, 11))
      0, 1, 2, 3, 4: return CHAR_ZERO + 8'($urandom_range(0, 9));
      5:             return 8'h20;
      6:             return ($urandom_range(0, 4) == 0) ? 8'h20 : 8'($urandom_range(9, 13));
      7:             return CHAR_PLUS;
      8:             return CHAR_MINUS;
      default:       return body_char();
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] c);
    int gap;
    push      <= 1'b1;
    rx_byte_i <= c;
    do @(posedge clk_i); while (full);
    if (c == CHAR_START || board.in_sent) counted++;
    board.note_byte(c);
    gap = snd_steady ? 0 : idle_len();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_gain(input logic signed [15:0] g);
    cfg_valid_i <= 1'b1;
    gain_q8_i   <= g;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_gain(g);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic settle();
    push <= 1'b0;
    while (board.heading_queue.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic random_sequence();
    int kind;
    int cut;
    int n;
    kind = $urandom_range(0, 99);
    if (kind < 80) begin
      send_byte(CHAR_START);
      repeat (FIELD_FIRST - 1) send_byte(body_char());
      repeat (FIELD_LEN) send_byte(field_char());
      send_byte(body_char());
      send_byte(($urandom_range(0, 5) == 0) ? CHAR_NEWLINE : body_char());
    end else if (kind < 90) begin
      cut = $urandom_range(1, SENT_END_POS - 1);
      send_byte(CHAR_START);
      repeat (cut - 1) send_byte(body_char());
      send_byte($urandom_range(0, 1) ? CHAR_NEWLINE : CHAR_START);
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // result side: random pop gaps, plus one long hold on request
  initial begin
    int hold_left;
    int idle_left;
    hold_left = 0;
    idle_left = 0;
    pop <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) board.check_heading(heading_out_o);
      if (rcv_hold_req) begin
        rcv_hold_req = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (idle_left > 0) begin
        idle_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        if (!rcv_steady && $urandom_range(0, 5) == 0) idle_left = idle_len();
      end
    end
  end

  initial begin
    logic signed [15:0] gain_set [7];
    logic [7:0]         directed [$];
    push         <= 1'b0;
    rx_byte_i    <= '0;
    cfg_valid_i  <= 1'b0;
    gain_q8_i    <= '0;
    rst_ni       <= 1'b0;
    snd_steady   = 1'b0;
    rcv_steady   = 1'b0;
    rcv_hold_req = 1'b0;
    counted      = 0;
    board        = new();
    gain_set     = '{16'sd0, 16'sd32767, -16'sd32768, -16'sd256, 16'($urandom), 16'sd77,
                     16'($urandom)};
    // ignored bytes, early end, restart, newline as closing byte, fold of a large value
    directed = '{8'hff, 8'h00, CHAR_START, CHAR_NEWLINE, CHAR_START,
                 CHAR_START, "H", "C", "H", "D", "M", ",", CHAR_MINUS, "9", "9", ",",
                 CHAR_NEWLINE,
                 CHAR_START, "H", "C", "H", "D", "M", ",", "9", "9", "9", ",", "Z"};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_gain(16'sd256);
    foreach (directed[k]) send_byte(directed[k]);
    for (int ph = 0; ph < 7; ph++) begin
      settle();
      write_gain(gain_set[ph]);
      snd_steady = (ph == 1) || (ph == 3);
      rcv_steady = (ph == 3);
      if (ph == 1) rcv_hold_req = 1'b1;
      counted = 0;
      while (counted < PHASE_BYTES) random_sequence();
    end
    settle();
    if (board.errors == 0) begin
      $display("compass_heading_sentence_parser regression: pass");
    end else begin
      $display("compass_heading_sentence_parser regression: fail");
    end
    $finish;
  end

endmodule
